/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* design/htlb_pkg.sv */
// ---------------------------------------------------------------------------
// htlb_pkg
// Types, widths and helpers for the hex text line to byte decoder.
// ---------------------------------------------------------------------------
package htlb_pkg;

	localparam int CHAR_W       = 8;
	localparam int BYTE_W       = 8;
	localparam int NIBBLE_W     = 4;
	localparam int MAX_BYTES_W  = 12;
	localparam int BYTE_COUNT_W = 12;
	localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 12'd4095;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_CHAR = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_ODD      = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_BAD_CHAR = 2'd1,
		ERR_TOO_LONG = 2'd2
	} line_err_t;

	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

	typedef struct packed {
		logic                is_space;
		logic                is_hex;
		logic [NIBBLE_W-1:0] nibble;
	} char_class_t;

endpackage

/* design/htlb_if.sv */
// ---------------------------------------------------------------------------
// htlb_if
// Valid/ready stream channels for characters and decoded results.
// ---------------------------------------------------------------------------
interface htlb_in_if import htlb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ch;
	logic              line_end;

	modport source (output valid, output ch, output line_end, input ready);
	modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface htlb_out_if import htlb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [BYTE_W-1:0]       byte_value;
	logic                    is_status;
	logic [2:0]              status;
	logic [BYTE_COUNT_W-1:0] byte_count;

	modport source (output valid, output byte_value, output is_status, output status,
		output byte_count, input ready);
	modport sink (input valid, input byte_value, input is_status, input status,
		input byte_count, output ready);
endinterface

/* design/htlb_char_class.sv */
// ---------------------------------------------------------------------------
// htlb_char_class
// Classifies one character as whitespace, hex digit or other.
// ---------------------------------------------------------------------------
module htlb_char_class import htlb_pkg::*; (
	input  logic [CHAR_W-1:0] ch,
	output char_class_t       cls
);

	logic is_digit;
	logic is_upper;
	logic is_lower;
	logic [CHAR_W-1:0] value;

	always_comb begin
		is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_F);
		is_lower = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_F);
		if (is_upper) begin
			value = ch - CH_UPPER_A + LETTER_OFS;
		end else if (is_lower) begin
			value = ch - CH_LOWER_A + LETTER_OFS;
		end else begin
			value = ch - CH_ZERO;
		end
		cls.is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
		cls.is_hex   = is_digit || is_upper || is_lower;
		cls.nibble   = value[NIBBLE_W-1:0];
	end

endmodule

/* design/hex_text_line_to_bytes_top.sv */
// A character is held in the input register, and its result then in the result register.
// Throughput: one character per cycle while the result sink keeps up; the
// line state update between the input register and the result register
// sets this figure. A stalled result holds the input stage as well.
// Reset: arst_n clears the line state and the valid flags of both stages, max_bytes goes to 4095.
// ---------------------------------------------------------------------------
// hex_text_line_to_bytes_top
// Pairs ASCII hex digits into bytes and reports a status at each line end.
// ---------------------------------------------------------------------------
module hex_text_line_to_bytes_top import htlb_pkg::*; #(
	parameter int COUNT_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   max_bytes_we,
	input  logic [MAX_BYTES_W-1:0] max_bytes_wdata,
	htlb_in_if.sink                chars,
	htlb_out_if.source             results
);

	localparam int CW = (COUNT_BITS > MAX_BYTES_W) ? COUNT_BITS : MAX_BYTES_W;
	localparam logic [CW-1:0] CNT_MAX = CW'({COUNT_BITS{1'b1}});

	logic [MAX_BYTES_W-1:0] max_bytes_q;

	// Input stage.
	logic              valid_s1;
	logic [CHAR_W-1:0] ch_s1;
	logic              line_end_s1;

	// Line state.
	logic [NIBBLE_W-1:0]   high_nibble_q;
	logic                  pending_q;
	logic [COUNT_BITS-1:0] count_q;
	line_err_t             err_q;

	logic [NIBBLE_W-1:0]   high_nibble_d;
	logic                  pending_d;
	logic [COUNT_BITS-1:0] count_d;
	line_err_t             err_d;

	// Result stage.
	logic                    out_valid_q;
	logic [BYTE_W-1:0]       byte_value_q;
	logic                    is_status_q;
	status_t                 status_q;
	logic [BYTE_COUNT_W-1:0] byte_count_q;

	logic                    produce;
	logic [BYTE_W-1:0]       byte_value_d;
	logic                    is_status_d;
	status_t                 status_d;
	logic [BYTE_COUNT_W-1:0] byte_count_d;

	char_class_t cls;
	logic        can_load;
	logic        advance;
	logic [CW-1:0] cap;
	logic [CW-1:0] count_ext;
	logic [CW-1:0] count_d_ext;

	htlb_char_class u_class (
		.ch  (ch_s1),
		.cls (cls)
	);

	assign can_load     = !out_valid_q || results.ready;
	assign advance      = valid_s1 && can_load;
	assign chars.ready  = !valid_s1 || advance;

	always_comb begin
		cap = (CW'(max_bytes_q) < CNT_MAX) ? CW'(max_bytes_q) : CNT_MAX;
		count_ext = CW'(count_q);

		high_nibble_d = high_nibble_q;
		pending_d     = pending_q;
		count_d       = count_q;
		err_d         = err_q;
		produce       = 1'b0;
		byte_value_d  = '0;
		is_status_d   = 1'b0;
		status_d      = ST_OK;

		if (line_end_s1) begin
			produce     = 1'b1;
			is_status_d = 1'b1;
			case (err_q)
				ERR_BAD_CHAR: status_d = ST_BAD_CHAR;
				ERR_TOO_LONG: status_d = ST_TOO_LONG;
				default: begin
					if (pending_q) begin
						status_d = ST_ODD;
					end else if (count_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						status_d = ST_OK;
					end
				end
			endcase
			high_nibble_d = '0;
			pending_d     = 1'b0;
			count_d       = '0;
			err_d         = ERR_NONE;
		end else if ((err_q == ERR_NONE) && !cls.is_space) begin
			if (!cls.is_hex) begin
				err_d = ERR_BAD_CHAR;
			end else if (!pending_q) begin
				high_nibble_d = cls.nibble;
				pending_d     = 1'b1;
			end else if (count_ext >= cap) begin
				err_d = ERR_TOO_LONG;
			end else begin
				produce       = 1'b1;
				byte_value_d  = {high_nibble_q, cls.nibble};
				count_d       = count_q + 1'b1;
				pending_d     = 1'b0;
				high_nibble_d = '0;
			end
		end

		// A status result reports the count before the line clears.
		count_d_ext  = line_end_s1 ? count_ext : CW'(count_d);
		byte_count_d = count_d_ext[BYTE_COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RESET;
		end else if (max_bytes_we) begin
			max_bytes_q <= max_bytes_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1       <= chars.ch;
			line_end_s1 <= chars.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_nibble_q <= '0;
			pending_q     <= 1'b0;
			count_q       <= '0;
			err_q         <= ERR_NONE;
		end else if (advance) begin
			high_nibble_q <= high_nibble_d;
			pending_q     <= pending_d;
			count_q       <= count_d;
			err_q         <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			byte_value_q <= byte_value_d;
			is_status_q  <= is_status_d;
			status_q     <= status_d;
			byte_count_q <= byte_count_d;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.byte_value = byte_value_q;
	assign results.is_status  = is_status_q;
	assign results.status     = status_q;
	assign results.byte_count = byte_count_q;

endmodule

/* design/htlb_checker.sv */
// ---------------------------------------------------------------------------
// htlb_checker
// Port-level checks on the result channel of the decoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module htlb_checker import htlb_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic [BYTE_W-1:0]       res_byte_value,
	input logic                    res_is_status,
	input logic [2:0]              res_status,
	input logic [BYTE_COUNT_W-1:0] res_byte_count
);

	// A result that was not taken stays offered with the same contents.
	`ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_byte_value) && $stable(res_is_status) && $stable(res_status) && $stable(res_byte_count))

	// Byte transfers always carry an ok status and count the byte itself.
	`ASSERT_IMPLY(a_byte_ok, clk, arst_n, res_valid && !res_is_status, res_status == ST_OK)
	`ASSERT_IMPLY(a_byte_cnt, clk, arst_n, res_valid && !res_is_status, res_byte_count != '0)

	// A status transfer carries no byte, and empty lines report a zero count.
	`ASSERT_IMPLY(a_stat_zero, clk, arst_n, res_valid && res_is_status, res_byte_value == '0 && (res_status != ST_EMPTY || res_byte_count == '0))

endmodule

bind hex_text_line_to_bytes_top htlb_checker u_htlb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (results.valid),
	.res_ready      (results.ready),
	.res_byte_value (results.byte_value),
	.res_is_status  (results.is_status),
	.res_status     (results.status),
	.res_byte_count (results.byte_count)
);
